FILE: src/mtp_pkg.sv
// ----------------------------------------------------------------------------
// mtp_pkg
// Shared types and constants for the monomial term parser.
// ----------------------------------------------------------------------------
package mtp_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int RES_W           = 32;
    localparam int CHAR_W          = 8;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 7;
    localparam int STEP_MAX        = 4;
    localparam int TDATA_OUT_W     = 112;
    localparam int TDATA_PAD_W     = TDATA_OUT_W - (3 * RES_W + CHAR_W + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_VAR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_VAR = 1'd1;

    localparam logic [CFG_DATA_W-1:0] FIRST_VAR_RST  = 7'd120;
    localparam logic [CFG_DATA_W-1:0] SECOND_VAR_RST = 7'd121;

    localparam logic [CHAR_W-1:0] CH_HAT    = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_LPAR   = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAR   = 8'h29;
    localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_Z  = 8'h7A;

    typedef enum logic [3:0] {
        PH_FACTOR      = 4'd0,
        PH_COEF        = 4'd1,
        PH_AFTER_VAR   = 4'd2,
        PH_AFTER_HAT   = 4'd3,
        PH_EXP_PRE     = 4'd4,
        PH_EXP_DIG     = 4'd5,
        PH_PAREN_SIGN  = 4'd6,
        PH_PAREN_PRE   = 4'd7,
        PH_PAREN_DIG   = 4'd8,
        PH_PAREN_CLOSE = 4'd9,
        PH_COMMENT     = 4'd10
    } t_phase;

    typedef enum logic [1:0] {
        ACC_KEEP,
        ACC_LOAD,
        ACC_APPEND,
        ACC_ZERO
    } t_acc_op;

    typedef enum logic [1:0] {
        ADD_NONE,
        ADD_ONE,
        ADD_ZERO,
        ADD_ACCUM
    } t_add_sel;

    typedef struct packed {
        logic              paren_error;
        logic              stopped_by_end;
        logic [CHAR_W-1:0] stop_char;
        logic [RES_W-1:0]  second_exponent;
        logic [RES_W-1:0]  first_exponent;
        logic [RES_W-1:0]  coefficient;
    } t_result;

endpackage

FILE: src/mtp_parse.sv
// ----------------------------------------------------------------------------
// mtp_parse
// Per-character parse step: phase update, digit accumulation, exponent sums
// and coefficient product, all settled combinationally for each accepted character.
// ----------------------------------------------------------------------------
module mtp_parse #(
    parameter int VALUE_WIDTH = mtp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [mtp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mtp_pkg::CFG_DATA_W-1:0] i_cfg_wr_data,
    input  logic                           i_accept,
    input  logic [mtp_pkg::CHAR_W-1:0]     i_char,
    input  logic                           i_end,
    output logic                           o_emit,
    output mtp_pkg::t_result               o_result
);
    import mtp_pkg::*;

    localparam int VW = VALUE_WIDTH;

    logic [CFG_DATA_W-1:0] r_first_var;
    logic [CFG_DATA_W-1:0] r_second_var;

    t_phase        r_phase, r_ret;
    logic [VW-1:0] r_coef, r_accum, r_exp1, r_exp2;
    logic          r_neg, r_tgt, r_err;

    t_phase        n_phase, n_ret;
    logic          n_neg, n_tgt, done, skip;
    t_acc_op       acc_op;
    t_add_sel      add_sel;
    logic          add_neg, do_mul, err_set, emit;

    logic          is_blank, is_hash, is_nl, is_dig, is_hat, is_lpar, is_rpar;
    logic          is_minus, is_plus, is_lower, match1, match2;

    logic [VW-1:0]   dig_val, accum_x10, n_accum, add_val, add_term;
    logic [VW-1:0]   n_coef, n_exp1, n_exp2;
    logic [VW-1:0]   prod;
    logic [RES_W-1:0] coef_o, exp1_o, exp2_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_var  <= FIRST_VAR_RST;
            r_second_var <= SECOND_VAR_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_FIRST_VAR:  r_first_var  <= i_cfg_wr_data;
                CFG_SECOND_VAR: r_second_var <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        is_blank = !i_end && (i_char inside {[CH_TAB:CH_CR], CH_SPACE});
        is_hash  = !i_end && (i_char == CH_HASH);
        is_nl    = !i_end && (i_char == CH_NL);
        is_dig   = !i_end && (i_char inside {[CH_ZERO:CH_NINE]});
        is_hat   = !i_end && (i_char == CH_HAT);
        is_lpar  = !i_end && (i_char == CH_LPAR);
        is_rpar  = !i_end && (i_char == CH_RPAR);
        is_minus = !i_end && (i_char == CH_MINUS);
        is_plus  = !i_end && (i_char == CH_PLUS);
        is_lower = !i_end && (i_char inside {[CH_LOW_A:CH_LOW_Z]});
        match1   = is_lower && (i_char[CFG_DATA_W-1:0] == r_first_var);
        match2   = is_lower && (i_char[CFG_DATA_W-1:0] == r_second_var);
    end

    // Phase walk: a character may be re-examined in up to STEP_MAX phases.
    always_comb begin
        n_phase = r_phase;
        n_ret   = r_ret;
        n_neg   = r_neg;
        n_tgt   = r_tgt;
        done    = 1'b0;
        skip    = 1'b0;
        acc_op  = ACC_KEEP;
        add_sel = ADD_NONE;
        add_neg = 1'b0;
        do_mul  = 1'b0;
        err_set = 1'b0;
        emit    = 1'b0;
        for (int k = 0; k < STEP_MAX; k++) begin
            if (!done) begin
                skip = n_phase inside {PH_FACTOR, PH_AFTER_VAR, PH_AFTER_HAT, PH_EXP_PRE,
                                       PH_PAREN_SIGN, PH_PAREN_PRE, PH_PAREN_CLOSE};
                done = 1'b1;
                if (skip && is_blank) begin
                end else if (skip && is_hash) begin
                    n_ret   = n_phase;
                    n_phase = PH_COMMENT;
                end else begin
                    case (n_phase)
                        PH_COMMENT: begin
                            if (is_nl) begin
                                n_phase = n_ret;
                            end else if (i_end) begin
                                n_phase = n_ret;
                                done    = 1'b0;
                            end
                        end
                        PH_COEF: begin
                            if (is_dig) begin
                                acc_op = ACC_APPEND;
                            end else begin
                                do_mul  = 1'b1;
                                n_phase = PH_FACTOR;
                                done    = 1'b0;
                            end
                        end
                        PH_AFTER_VAR: begin
                            if (is_hat) begin
                                n_phase = PH_AFTER_HAT;
                            end else begin
                                add_sel = ADD_ONE;
                                add_neg = n_neg;
                                n_neg   = 1'b0;
                                n_phase = PH_FACTOR;
                                done    = 1'b0;
                            end
                        end
                        PH_AFTER_HAT, PH_EXP_PRE: begin
                            if (n_phase == PH_AFTER_HAT && is_lpar) begin
                                n_neg   = 1'b0;
                                n_phase = PH_PAREN_SIGN;
                            end else if (is_dig) begin
                                acc_op  = ACC_LOAD;
                                n_phase = PH_EXP_DIG;
                            end else begin
                                add_sel = ADD_ZERO;
                                add_neg = n_neg;
                                n_neg   = 1'b0;
                                n_phase = PH_FACTOR;
                                done    = 1'b0;
                            end
                        end
                        PH_EXP_DIG: begin
                            if (is_dig) begin
                                acc_op = ACC_APPEND;
                            end else begin
                                add_sel = ADD_ACCUM;
                                add_neg = n_neg;
                                n_neg   = 1'b0;
                                n_phase = PH_FACTOR;
                                done    = 1'b0;
                            end
                        end
                        PH_PAREN_SIGN, PH_PAREN_PRE: begin
                            if (n_phase == PH_PAREN_SIGN && (is_minus || is_plus)) begin
                                acc_op  = ACC_ZERO;
                                n_neg   = is_minus;
                                n_phase = PH_PAREN_PRE;
                            end else if (is_dig) begin
                                acc_op  = ACC_LOAD;
                                n_phase = PH_PAREN_DIG;
                            end else begin
                                acc_op  = ACC_ZERO;
                                n_phase = PH_PAREN_CLOSE;
                                done    = 1'b0;
                            end
                        end
                        PH_PAREN_DIG: begin
                            if (is_dig) begin
                                acc_op = ACC_APPEND;
                            end else begin
                                n_phase = PH_PAREN_CLOSE;
                                done    = 1'b0;
                            end
                        end
                        PH_PAREN_CLOSE: begin
                            add_sel = (acc_op == ACC_ZERO) ? ADD_ZERO : ADD_ACCUM;
                            add_neg = n_neg;
                            n_neg   = 1'b0;
                            n_phase = PH_FACTOR;
                            if (!is_rpar) begin
                                err_set = 1'b1;
                                done    = 1'b0;
                            end
                        end
                        default: begin
                            if (is_dig) begin
                                acc_op  = ACC_LOAD;
                                n_phase = PH_COEF;
                            end else if (match1) begin
                                n_tgt   = 1'b0;
                                n_neg   = 1'b0;
                                n_phase = PH_AFTER_VAR;
                            end else if (match2) begin
                                n_tgt   = 1'b1;
                                n_neg   = 1'b0;
                                n_phase = PH_AFTER_VAR;
                            end else begin
                                emit = 1'b1;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // Datapath: at most one digit, one exponent add and one multiply per transfer.
    always_comb begin
        dig_val   = VW'(i_char[3:0]);
        accum_x10 = (r_accum << 3) + (r_accum << 1);
        case (acc_op)
            ACC_LOAD:   n_accum = dig_val;
            ACC_APPEND: n_accum = accum_x10 + dig_val;
            ACC_ZERO:   n_accum = '0;
            default:    n_accum = r_accum;
        endcase
        case (add_sel)
            ADD_ONE:   add_val = VW'(1);
            ADD_ACCUM: add_val = r_accum;
            default:   add_val = '0;
        endcase
        add_term = add_neg ? (~add_val + VW'(1)) : add_val;
        n_exp1   = r_exp1;
        n_exp2   = r_exp2;
        if (add_sel != ADD_NONE) begin
            if (r_tgt) begin
                n_exp2 = r_exp2 + add_term;
            end else begin
                n_exp1 = r_exp1 + add_term;
            end
        end
        prod   = r_coef * r_accum;
        n_coef = do_mul ? prod : r_coef;
    end

    if (VW >= RES_W) begin : g_trunc
        assign coef_o = n_coef[RES_W-1:0];
        assign exp1_o = n_exp1[RES_W-1:0];
        assign exp2_o = n_exp2[RES_W-1:0];
    end else begin : g_ext
        assign coef_o = {{(RES_W-VW){1'b0}}, n_coef};
        assign exp1_o = {{(RES_W-VW){1'b0}}, n_exp1};
        assign exp2_o = {{(RES_W-VW){1'b0}}, n_exp2};
    end

    assign o_emit                   = i_accept && emit;
    assign o_result.coefficient     = coef_o;
    assign o_result.first_exponent  = exp1_o;
    assign o_result.second_exponent = exp2_o;
    assign o_result.stop_char       = i_end ? '0 : i_char;
    assign o_result.stopped_by_end  = i_end;
    assign o_result.paren_error     = r_err || err_set;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && emit)) begin
            r_phase <= PH_FACTOR;
            r_ret   <= PH_FACTOR;
            r_coef  <= VW'(1);
            r_accum <= '0;
            r_exp1  <= '0;
            r_exp2  <= '0;
            r_neg   <= 1'b0;
            r_tgt   <= 1'b0;
            r_err   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_ret   <= n_ret;
            r_coef  <= n_coef;
            r_accum <= n_accum;
            r_exp1  <= n_exp1;
            r_exp2  <= n_exp2;
            r_neg   <= n_neg;
            r_tgt   <= n_tgt;
            r_err   <= r_err || err_set;
        end
    end

endmodule

FILE: src/mtp_out_buf.sv
// ----------------------------------------------------------------------------
// mtp_out_buf
// Two-entry result buffer; decouples the parser from downstream stalls.
// ----------------------------------------------------------------------------
module mtp_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mtp_pkg::t_result i_data,
    output logic             o_ready,
    output logic             o_valid,
    output mtp_pkg::t_result o_data,
    input  logic             i_ready
);
    import mtp_pkg::*;

    t_result    r_slot0, r_slot1;
    logic [1:0] r_cnt;
    logic       pop;

    assign pop     = (r_cnt != 2'd0) && i_ready;
    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_slot0 <= r_slot1;
        end
        if (i_push) begin
            if (r_cnt == 2'd0 || (r_cnt == 2'd1 && pop)) begin
                r_slot0 <= i_data;
            end else begin
                r_slot1 <= i_data;
            end
        end
    end

endmodule

FILE: src/monomial_term_parser.sv
// ----------------------------------------------------------------------------
// monomial_term_parser
// Byte-stream parser for one monomial in two variables per result.
//
// Input stream: one character per transfer; tdata = char_code, tuser flags
// end of text in place of a character. Output stream: one transfer per
// parsed monomial (coefficient, two exponent sums, stop character, flags).
// The parse step handles each input transfer; the result of a character that
// ends a monomial is in the output buffer in the cycle after its transfer.
// One character is taken every cycle while the two-entry output buffer has
// room, so input keeps flowing while a result waits and stalls only when both
// entries are held by a stalled receiver. The user must set variable letters
// through the write port while the block is idle; the block does not enforce
// this. Reset (synchronous, active low) empties the buffer, restores the
// letters to 'x' and 'y' and starts a fresh monomial.
// ----------------------------------------------------------------------------
module monomial_term_parser #(
    parameter int VALUE_WIDTH = mtp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [mtp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mtp_pkg::CFG_DATA_W-1:0]   i_cfg_wr_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [mtp_pkg::CHAR_W-1:0]       s_axis_tdata,  // [7:0] char_code
    input  logic                             s_axis_tuser,  // [0] end_of_text
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [31:0] coefficient, [63:32] first_exponent, [95:64] second_exponent,
    // [103:96] stop_char, [104] paren_error, [111:105] zero
    output logic [mtp_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tuser   // [0] stopped_by_end
);
    import mtp_pkg::*;

    logic    accept, emit, buf_ready;
    t_result result, head;

    assign accept        = s_axis_tvalid && buf_ready;
    assign s_axis_tready = buf_ready;

    mtp_parse #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_accept     (accept),
        .i_char       (s_axis_tdata),
        .i_end        (s_axis_tuser),
        .o_emit       (emit),
        .o_result     (result)
    );

    mtp_out_buf u_out_buf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (emit),
        .i_data (result),
        .o_ready(buf_ready),
        .o_valid(m_axis_tvalid),
        .o_data (head),
        .i_ready(m_axis_tready)
    );

    assign m_axis_tdata = {{TDATA_PAD_W{1'b0}}, head.paren_error, head.stop_char,
                           head.second_exponent, head.first_exponent, head.coefficient};
    assign m_axis_tuser = head.stopped_by_end;

endmodule

FILE: test/monomial_term_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// monomial_term_parser_test
// Self-checking stream test of the monomial term parser.
//
// A queue of characters, a short hand-written sequence and then randomly built
// monomials under several variable-letter settings, is streamed into the
// parser in random bursts. Every accepted character runs through a local
// parse model; each finished monomial is queued and compared field by field
// with the next output transfer. The receiver stalls on its own pattern and,
// now and then, holds off long enough to back the parser up.
// ----------------------------------------------------------------------------
module monomial_term_parser_test;

    import mtp_pkg::*;

    localparam logic [CHAR_W-1:0] CH_VT = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF = 8'h0C;
    localparam int PHASE_ITEMS = 235;
    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              eot;
    } t_char_item;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = CFG_FIRST_VAR;
    logic [CFG_DATA_W-1:0]    i_cfg_wr_data = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [CHAR_W-1:0]        s_axis_tdata = '0;
    logic                     s_axis_tuser = 1'b0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0]   m_axis_tdata;
    logic                     m_axis_tuser;

    monomial_term_parser uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // parse model state
    logic [CFG_DATA_W-1:0] letter_first = FIRST_VAR_RST;
    logic [CFG_DATA_W-1:0] letter_second = SECOND_VAR_RST;
    t_phase                phase_q = PH_FACTOR;
    t_phase                resume_phase = PH_FACTOR;
    logic [RES_W-1:0]      coef_acc = 32'd1;
    logic [RES_W-1:0]      digit_acc = '0;
    logic [RES_W-1:0]      first_sum = '0;
    logic [RES_W-1:0]      second_sum = '0;
    logic                  exp_neg = 1'b0;
    logic                  exp_to_second = 1'b0;
    logic                  paren_bad = 1'b0;

    t_char_item  pending_chars[$];
    t_result     expected_terms[$];
    int          items_queued = 0;
    int          mismatches = 0;
    int          results_seen = 0;
    int          idle_cycles = 0;
    bit          in_taken = 1'b0;
    bit          in_fire;
    bit          out_fire;
    bit          term_done;
    t_result     fresh_term;
    t_result     want;
    t_char_item  drive_item;
    int          gap_left = 0;
    int          burst_left = 1;
    int          hold_left = 0;
    int          next_hold_at = 60;
    int          rx_mode = 0;
    int          mode_left = 0;
    int          rx_cycle = 0;

    logic [CHAR_W-1:0] blank_set[6] = '{CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR};
    string             stop_chars = "*+-),;=A/[~";

    function automatic void clear_term();
        phase_q       = PH_FACTOR;
        resume_phase  = PH_FACTOR;
        coef_acc      = 32'd1;
        digit_acc     = '0;
        first_sum     = '0;
        second_sum    = '0;
        exp_neg       = 1'b0;
        exp_to_second = 1'b0;
        paren_bad     = 1'b0;
    endfunction

    function automatic void add_power(input logic [RES_W-1:0] v);
        logic [RES_W-1:0] e;
        e = exp_neg ? (32'd0 - v) : v;
        if (exp_to_second)
            second_sum = second_sum + e;
        else
            first_sum = first_sum + e;
        exp_neg = 1'b0;
    endfunction

    function automatic void push_digit(input logic [CHAR_W-1:0] code);
        digit_acc = digit_acc * 10 + {28'd0, code[3:0]};
    endfunction

    task automatic parse_char(input logic [CHAR_W-1:0] code, input logic eot,
                              output bit done, output t_result res);
        bit again;
        bit skip;
        bit blank;
        bit digit;
        bit lower;
        done  = 1'b0;
        res   = '0;
        again = 1'b1;
        blank = !eot && (code == CH_SPACE || code == CH_TAB || code == CH_NL ||
                         code == CH_VT || code == CH_FF || code == CH_CR);
        digit = !eot && code >= CH_ZERO && code <= CH_NINE;
        lower = !eot && code >= CH_LOW_A && code <= CH_LOW_Z;
        while (again) begin
            again = 1'b0;
            skip = (phase_q == PH_FACTOR) || (phase_q == PH_AFTER_VAR) ||
                   (phase_q == PH_AFTER_HAT) || (phase_q == PH_EXP_PRE) ||
                   (phase_q == PH_PAREN_SIGN) || (phase_q == PH_PAREN_PRE) ||
                   (phase_q == PH_PAREN_CLOSE);
            if (skip && blank) begin
            end else if (skip && !eot && code == CH_HASH) begin
                resume_phase = phase_q;
                phase_q = PH_COMMENT;
            end else begin
                case (phase_q)
                    PH_COMMENT: begin
                        if (!eot && code == CH_NL) begin
                            phase_q = resume_phase;
                        end else if (eot) begin
                            phase_q = resume_phase;
                            again = 1'b1;
                        end
                    end
                    PH_COEF: begin
                        if (digit) begin
                            push_digit(code);
                        end else begin
                            coef_acc = coef_acc * digit_acc;
                            phase_q = PH_FACTOR;
                            again = 1'b1;
                        end
                    end
                    PH_AFTER_VAR: begin
                        if (!eot && code == CH_HAT) begin
                            phase_q = PH_AFTER_HAT;
                        end else begin
                            add_power(32'd1);
                            phase_q = PH_FACTOR;
                            again = 1'b1;
                        end
                    end
                    PH_AFTER_HAT, PH_EXP_PRE: begin
                        if (phase_q == PH_AFTER_HAT && !eot && code == CH_LPAR) begin
                            exp_neg = 1'b0;
                            phase_q = PH_PAREN_SIGN;
                        end else if (digit) begin
                            digit_acc = '0;
                            push_digit(code);
                            phase_q = PH_EXP_DIG;
                        end else begin
                            add_power(32'd0);
                            phase_q = PH_FACTOR;
                            again = 1'b1;
                        end
                    end
                    PH_EXP_DIG: begin
                        if (digit) begin
                            push_digit(code);
                        end else begin
                            add_power(digit_acc);
                            phase_q = PH_FACTOR;
                            again = 1'b1;
                        end
                    end
                    PH_PAREN_SIGN, PH_PAREN_PRE: begin
                        digit_acc = '0;
                        if (phase_q == PH_PAREN_SIGN && !eot &&
                            (code == CH_MINUS || code == CH_PLUS)) begin
                            exp_neg = (code == CH_MINUS);
                            phase_q = PH_PAREN_PRE;
                        end else if (digit) begin
                            push_digit(code);
                            phase_q = PH_PAREN_DIG;
                        end else begin
                            phase_q = PH_PAREN_CLOSE;
                            again = 1'b1;
                        end
                    end
                    PH_PAREN_DIG: begin
                        if (digit) begin
                            push_digit(code);
                        end else begin
                            phase_q = PH_PAREN_CLOSE;
                            again = 1'b1;
                        end
                    end
                    PH_PAREN_CLOSE: begin
                        add_power(digit_acc);
                        phase_q = PH_FACTOR;
                        if (eot || code != CH_RPAR) begin
                            paren_bad = 1'b1;
                            again = 1'b1;
                        end
                    end
                    default: begin
                        if (digit) begin
                            digit_acc = '0;
                            push_digit(code);
                            phase_q = PH_COEF;
                        end else if (lower && code == {1'b0, letter_first}) begin
                            exp_to_second = 1'b0;
                            exp_neg = 1'b0;
                            phase_q = PH_AFTER_VAR;
                        end else if (lower && code == {1'b0, letter_second}) begin
                            exp_to_second = 1'b1;
                            exp_neg = 1'b0;
                            phase_q = PH_AFTER_VAR;
                        end else begin
                            res.coefficient     = coef_acc;
                            res.first_exponent  = first_sum;
                            res.second_exponent = second_sum;
                            res.stop_char       = eot ? 8'd0 : code;
                            res.stopped_by_end  = eot;
                            res.paren_error     = paren_bad;
                            done = 1'b1;
                            clear_term();
                        end
                    end
                endcase
            end
        end
    endtask

    task automatic check_field(input string name, input logic [RES_W-1:0] exp_val,
                               input logic [RES_W-1:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // ---------------- stimulus building ----------------
    task automatic push_item(input logic [CHAR_W-1:0] code, input logic eot);
        t_char_item it;
        it.code = code;
        it.eot  = eot;
        pending_chars.push_back(it);
        items_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_item(s[i], 1'b0);
    endtask

    task automatic gen_blanks();
        int r;
        logic [CHAR_W-1:0] c;
        r = $urandom_range(0, 9);
        if (r >= 5 && r <= 8) begin
            repeat ($urandom_range(1, 3)) push_item(blank_set[$urandom_range(0, 5)], 1'b0);
        end else if (r == 9) begin
            push_item(CH_HASH, 1'b0);
            repeat ($urandom_range(0, 5)) begin
                c = CHAR_W'($urandom_range(0, 255));
                push_item((c == CH_NL) ? CH_SPACE : c, 1'b0);
            end
            push_item(CH_NL, 1'b0);
        end
    endtask

    task automatic gen_digits(input int min_n);
        int n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
        if (min_n == 0 && $urandom_range(0, 3) == 0)
            n = 0;
        repeat (n) push_item(CH_ZERO + CHAR_W'($urandom_range(0, 9)), 1'b0);
    endtask

    task automatic gen_power();
        int r;
        int s;
        r = $urandom_range(0, 9);
        if (r >= 4 && r <= 5) begin
            gen_blanks();
            push_item(CH_HAT, 1'b0);
            gen_blanks();
            gen_digits(1);
        end else if (r >= 6 && r <= 8) begin
            push_item(CH_HAT, 1'b0);
            gen_blanks();
            push_item(CH_LPAR, 1'b0);
            gen_blanks();
            s = $urandom_range(0, 2);
            if (s == 1)
                push_item(CH_MINUS, 1'b0);
            else if (s == 2)
                push_item(CH_PLUS, 1'b0);
            gen_blanks();
            gen_digits(r == 8 ? 0 : 1);
            gen_blanks();
            if (r != 8)
                push_item(CH_RPAR, 1'b0);
        end else if (r == 9) begin
            push_item(CH_HAT, 1'b0);
            if ($urandom_range(0, 1) == 1) begin
                push_item(CH_LPAR, 1'b0);
                push_item(CH_RPAR, 1'b0);
            end
        end
    endtask

    task automatic gen_monomial();
        int r;
        logic [CHAR_W-1:0] va;
        logic [CHAR_W-1:0] vb;
        va = {1'b0, letter_first};
        vb = {1'b0, letter_second};
        if (va < CH_LOW_A || va > CH_LOW_Z)
            va = CHAR_W'($urandom_range(CH_LOW_A, CH_LOW_Z));
        if (vb < CH_LOW_A || vb > CH_LOW_Z)
            vb = CHAR_W'($urandom_range(CH_LOW_A, CH_LOW_Z));
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4))
                push_item(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        repeat ($urandom_range(0, 4)) begin
            gen_blanks();
            if ($urandom_range(0, 9) < 3) begin
                gen_digits(1);
            end else begin
                push_item($urandom_range(0, 1) ? va : vb, 1'b0);
                gen_power();
            end
        end
        gen_blanks();
        r = $urandom_range(0, 9);
        if (r < 3)
            push_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
        else if (r < 7)
            push_item(stop_chars[$urandom_range(0, stop_chars.len() - 1)], 1'b0);
        else
            push_item(CHAR_W'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic run_random();
        int start;
        start = items_queued;
        while (items_queued - start < PHASE_ITEMS)
            gen_monomial();
        push_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic drain();
        while (pending_chars.size() != 0 || s_axis_tvalid || expected_terms.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_letters(input logic [CFG_DATA_W-1:0] fa,
                               input logic [CFG_DATA_W-1:0] fb);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= CFG_FIRST_VAR;
        i_cfg_wr_data <= fa;
        @(negedge i_clk);
        i_cfg_index   <= CFG_SECOND_VAR;
        i_cfg_wr_data <= fb;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        letter_first  = fa;
        letter_second = fb;
    endtask

    // ---------------- sender ----------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_chars.size() > 0) begin
                drive_item = pending_chars.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= drive_item.code;
                s_axis_tuser  <= drive_item.eot;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300)
                                                              : $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- receiver ----------------
    always @(negedge i_clk) begin
        rx_cycle++;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (results_seen >= next_hold_at && pending_chars.size() > 20) begin
            hold_left = LONG_HOLD;
            next_hold_at = next_hold_at + 120;
            m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ((rx_cycle % 5) < 2);
            endcase
        end
    end

    // ---------------- monitor, prediction, watchdog ----------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            out_fire = m_axis_tvalid && m_axis_tready;
            in_fire  = s_axis_tvalid && s_axis_tready;
            if (out_fire) begin
                results_seen++;
                if (expected_terms.size() == 0) begin
                    $error("output transfer with no monomial pending");
                    mismatches++;
                end else begin
                    want = expected_terms.pop_front();
                    check_field("coefficient", want.coefficient, m_axis_tdata[31:0]);
                    check_field("first_exponent", want.first_exponent, m_axis_tdata[63:32]);
                    check_field("second_exponent", want.second_exponent,
                                m_axis_tdata[95:64]);
                    check_field("stop_char", {24'd0, want.stop_char},
                                {24'd0, m_axis_tdata[103:96]});
                    check_field("paren_error", {31'd0, want.paren_error},
                                {31'd0, m_axis_tdata[104]});
                    check_field("stopped_by_end", {31'd0, want.stopped_by_end},
                                {31'd0, m_axis_tuser});
                    check_field("tdata padding", 32'd0, {25'd0, m_axis_tdata[111:105]});
                end
            end
            if (in_fire) begin
                parse_char(s_axis_tdata, s_axis_tuser, term_done, fresh_term);
                if (term_done)
                    expected_terms.push_back(fresh_term);
            end
            in_taken = in_fire;
        end
        if (in_fire || out_fire)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // blank inside a number, high byte as stop
        push_text("12 3x");
        push_item(8'hFF, 1'b0);
        // open parenthesis never closed
        push_text("y^(-7*");
        push_item(8'h00, 1'b0);
        // bare hat, empty parentheses, comment, end of input
        push_text("x^y^()x^9#\n");
        push_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
        run_random();
        drain();

        set_letters(CH_LOW_A[6:0], CH_LOW_Z[6:0]);
        run_random();
        drain();
        set_letters(CH_LOW_Z[6:0], CH_LOW_A[6:0]);
        run_random();
        drain();
        set_letters(7'd113, 7'd113);
        run_random();
        drain();
        set_letters(7'd48, 7'd127);
        run_random();
        drain();
        set_letters(CFG_DATA_W'($urandom_range(CH_LOW_A, CH_LOW_Z)),
                    CFG_DATA_W'($urandom_range(CH_LOW_A, CH_LOW_Z)));
        run_random();
        drain();
        set_letters(FIRST_VAR_RST, SECOND_VAR_RST);
        run_random();
        drain();

        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && expected_terms.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
